@@ hw/rtl/vn_pkg.sv @@
// ----------------------------------------------------------------------------
// vn_pkg
// Types and constants shared by the vector normalize pipeline.
// ----------------------------------------------------------------------------
package vn_pkg;

    localparam int LANES     = 3;
    localparam int COMP_W    = 32;
    localparam int SUM_W     = 2 * COMP_W;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    // Quotient bits: the unit value 1.0 in Q2.30 needs 31 bits.
    localparam int FRAC_BITS = 30;
    localparam int QUO_W     = FRAC_BITS + 1;

    // Per-request data that rides alongside the arithmetic.
    typedef struct packed {
        logic [LANES-1:0]             neg;
        logic                         zero;
        logic [LANES-1:0][COMP_W-1:0] absval;
    } side_t;

endpackage

@@ hw/rtl/vn_isqrt.sv @@
// ----------------------------------------------------------------------------
// vn_isqrt
// Pipelined integer square root: one result bit per register stage.
// ----------------------------------------------------------------------------
module vn_isqrt
    import vn_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [SUM_W-1:0]    in_sum,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [ROOT_W-1:0]   out_root,
    output side_t               out_side
);

    logic [ROOT_W:0]               valid_reg;
    logic [ROOT_W:0][SUM_W-1:0]    sum_reg;
    logic [ROOT_W:0][REM_W-1:0]    rem_reg;
    logic [ROOT_W:0][ROOT_W-1:0]   root_reg;
    side_t [ROOT_W:0]              side_reg;

    assign valid_reg[0] = in_valid;
    assign sum_reg[0]   = in_sum;
    assign rem_reg[0]   = '0;
    assign root_reg[0]  = '0;
    assign side_reg[0]  = in_side;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W+1:0]  rem_shift;
        logic [REM_W+1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb
        begin
            rem_shift = {rem_reg[k], sum_reg[k][SUM_W-1-2*k -: 2]};
            trial     = {2'b00, root_reg[k], 2'b01};
            take      = (rem_shift >= trial);
            rem_next  = take ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
            root_next = {root_reg[k][ROOT_W-2:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sum_reg[k+1]  <= sum_reg[k];
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W];
    assign out_root  = root_reg[ROOT_W];
    assign out_side  = side_reg[ROOT_W];

endmodule

@@ hw/rtl/vn_divide.sv @@
// ----------------------------------------------------------------------------
// vn_divide
// Pipelined restoring division of each component by the magnitude, three
// lanes side by side, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module vn_divide
    import vn_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [ROOT_W-1:0]            in_mag,
    input  side_t                        in_side,
    output logic                         out_valid,
    output logic [LANES-1:0][QUO_W-1:0]  out_quo,
    output logic [ROOT_W-1:0]            out_mag,
    output side_t                        out_side
);

    logic [QUO_W:0]                          valid_reg;
    logic [QUO_W:0][ROOT_W-1:0]              mag_reg;
    logic [QUO_W:0][LANES-1:0][ROOT_W-1:0]   rem_reg;
    logic [QUO_W:0][LANES-1:0][QUO_W-1:0]    quo_reg;
    side_t [QUO_W:0]                         side_reg;

    assign valid_reg[0] = in_valid;
    assign mag_reg[0]   = in_mag;
    assign rem_reg[0]   = '0;
    assign quo_reg[0]   = '0;
    assign side_reg[0]  = in_side;

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [LANES-1:0][ROOT_W-1:0] rem_next;
        logic [LANES-1:0][QUO_W-1:0]  quo_next;

        always_comb
        begin
            logic [ROOT_W:0] part;
            logic            take;
            for (int l = 0; l < LANES; l++)
            begin
                // The first step starts from the component itself, the
                // rest shift in the zero fraction bits.
                if (k == 0)
                begin
                    part = {1'b0, side_reg[k].absval[l]};
                end
                else
                begin
                    part = {rem_reg[k][l], 1'b0};
                end
                take        = (part >= {1'b0, mag_reg[k]});
                rem_next[l] = take ? ROOT_W'(part - {1'b0, mag_reg[k]}) : ROOT_W'(part);
                quo_next[l] = {quo_reg[k][l][QUO_W-2:0], take};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mag_reg[k+1]  <= mag_reg[k];
                rem_reg[k+1]  <= rem_next;
                quo_reg[k+1]  <= quo_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[QUO_W];
    assign out_quo   = quo_reg[QUO_W];
    assign out_mag   = mag_reg[QUO_W];
    assign out_side  = side_reg[QUO_W];

endmodule

@@ hw/rtl/vector3_normalize_core.sv @@
// ----------------------------------------------------------------------------
// vector3_normalize_core
// Length and unit vector of a signed Q16.16 3-component vector.
// ----------------------------------------------------------------------------
// A request on the s_axis channel carries x, y and z. The result on m_axis
// carries the unit vector in signed Q2.30 (truncated toward zero), the
// length in unsigned Q16.16 and, on tuser, a flag for the all-zero vector,
// whose outputs are all zero.
// The pipeline has 3 front stages (absolute value, squares, sum), 32 square
// root stages (one root bit each) and 31 division stages (one quotient bit
// each, three lanes), 66 register stages in all.
// One request is accepted per cycle for as long as the output is taken.
// The whole pipeline advances together: when the result in the last stage
// is not taken, every stage holds and s_axis_tready drops, so nothing is
// lost or repeated. Reset empties the pipeline; no other state exists.
// ----------------------------------------------------------------------------
module vector3_normalize_core
    import vn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // vec_x, vec_y, vec_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // unit_x, unit_y, unit_z, magnitude
    output logic [0:0]   m_axis_tuser    // zero_vector
);

    logic en;

    logic                            a_valid_reg;
    logic [LANES-1:0]                a_neg_reg;
    logic [LANES-1:0][COMP_W-1:0]    a_abs_reg;
    logic                            b_valid_reg;
    logic [LANES-1:0]                b_neg_reg;
    logic [LANES-1:0][COMP_W-1:0]    b_abs_reg;
    logic [LANES-1:0][SUM_W-1:0]     b_sq_reg;
    logic                            c_valid_reg;
    logic [SUM_W-1:0]                c_sum_reg;
    side_t                           c_side_reg;

    logic [LANES-1:0][COMP_W-1:0]    comp;
    logic [LANES-1:0][COMP_W-1:0]    abs_next;

    logic                            sq_valid;
    logic [ROOT_W-1:0]               sq_root;
    side_t                           sq_side;
    logic                            dv_valid;
    logic [LANES-1:0][QUO_W-1:0]     dv_quo;
    logic [ROOT_W-1:0]               dv_mag;
    side_t                           dv_side;
    logic [LANES-1:0][COMP_W-1:0]    unit;

    assign en            = !dv_valid || m_axis_tready;
    assign s_axis_tready = en;
    assign comp          = s_axis_tdata;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            abs_next[l] = comp[l][COMP_W-1] ? COMP_W'(-comp[l]) : comp[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= s_axis_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                a_neg_reg[l] <= comp[l][COMP_W-1];
                b_sq_reg[l]  <= SUM_W'(a_abs_reg[l]) * SUM_W'(a_abs_reg[l]);
            end
            a_abs_reg         <= abs_next;
            b_neg_reg         <= a_neg_reg;
            b_abs_reg         <= a_abs_reg;
            // Three squares of at most 2^62 each cannot overflow 64 bits.
            c_sum_reg         <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
            c_side_reg.neg    <= b_neg_reg;
            c_side_reg.absval <= b_abs_reg;
            c_side_reg.zero   <= (b_abs_reg == '0);
        end
    end

    vn_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .in_sum    (c_sum_reg),
        .in_side   (c_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    vn_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_mag    (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_mag   (dv_mag),
        .out_side  (dv_side)
    );

    // A zero magnitude makes the divider meaningless; the flag forces zero.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (dv_side.zero)
            begin
                unit[l] = '0;
            end
            else if (dv_side.neg[l])
            begin
                unit[l] = COMP_W'(-{1'b0, dv_quo[l]});
            end
            else
            begin
                unit[l] = COMP_W'(dv_quo[l]);
            end
        end
    end

    assign m_axis_tvalid = dv_valid;
    assign m_axis_tdata  = {dv_mag, unit[2], unit[1], unit[0]};
    assign m_axis_tuser  = dv_side.zero;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for vector3_normalize_core.
// ----------------------------------------------------------------------------
// Random and directed vectors are sent on s_axis while both sides idle at
// random. Each accepted request is predicted in integer arithmetic (sum of
// squares, bitwise square root, fixed-point division) and the results are
// compared in order against m_axis.
// ----------------------------------------------------------------------------

class norm_scoreboard;
    typedef struct packed {
        logic [31:0] ux;
        logic [31:0] uy;
        logic [31:0] uz;
        logic [31:0] mag;
        logic        zero;
    } norm_result_t;

    norm_result_t pending[$];
    int           errors;
    int           checked;

    function automatic logic [63:0] root_of(logic [63:0] s);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (s >= root + bitv) begin
                s    = s - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [31:0] unit_of(logic [31:0] c, logic [63:0] mag);
        logic [63:0] a;
        logic [63:0] q;
        a = c[31] ? (64'h1_0000_0000 - {32'd0, c}) : {32'd0, c};
        q = (a << 30) / mag;
        if (c[31])
            q = 64'd0 - q;
        return q[31:0];
    endfunction

    function void note_request(logic [95:0] d);
        norm_result_t r;
        logic [31:0]  c[3];
        logic [63:0]  a;
        logic [63:0]  sum;
        logic [63:0]  mag;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            c[i] = d[32*i +: 32];
            a    = c[i][31] ? (64'h1_0000_0000 - {32'd0, c[i]}) : {32'd0, c[i]};
            sum  = sum + a * a;
        end
        if (sum == 0) begin
            r = '0;
            r.zero = 1'b1;
        end
        else begin
            mag    = root_of(sum);
            r.ux   = unit_of(c[0], mag);
            r.uy   = unit_of(c[1], mag);
            r.uz   = unit_of(c[2], mag);
            r.mag  = mag[31:0];
            r.zero = 1'b0;
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [127:0] d, logic u);
        norm_result_t e;
        norm_result_t got;
        got = {d[31:0], d[63:32], d[95:64], d[127:96], u};
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        e = pending.pop_front();
        checked++;
        if (got.ux !== e.ux) begin
            $display("%0t: unit_x expected %h actual %h", $time, e.ux, got.ux);
            errors++;
        end
        if (got.uy !== e.uy) begin
            $display("%0t: unit_y expected %h actual %h", $time, e.uy, got.uy);
            errors++;
        end
        if (got.uz !== e.uz) begin
            $display("%0t: unit_z expected %h actual %h", $time, e.uz, got.uz);
            errors++;
        end
        if (got.mag !== e.mag) begin
            $display("%0t: magnitude expected %h actual %h", $time, e.mag, got.mag);
            errors++;
        end
        if (got.zero !== e.zero) begin
            $display("%0t: zero_vector expected %b actual %b", $time, e.zero, got.zero);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import vn_pkg::*;

    localparam int LATENCY   = 66;
    localparam int CYCLE_CAP = 400000;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    norm_scoreboard board;
    int             cycles;
    bit             hold_sink;
    bit             sink_hold_done;

    vector3_normalize_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        hold_sink      = 1'b0;
        sink_hold_done = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Monitor: sample both channels at the edge where a transfer happens.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.note_request(s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // Receiver: random stalls per result, plus one long hold-off on request.
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge clk);
                sink_hold_done = 1'b1;
                hold_sink      = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    function automatic logic [31:0] rand_comp(int mode);
        case (mode)
            0:       return $urandom();
            1:       return $urandom_range(0, 255) - 128;
            2:       return $urandom_range(0, 131071) - 65536;
            default: return {32{1'($urandom_range(0, 1))}} ^ 32'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] corner[6];
        cycles = 0;
        corner = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero vector, extremes, single axes, mixed signs.
        send_vector(0, 0, 0, 0);
        for (int i = 1; i < 6; i++) begin
            send_vector(corner[i], 0, 0, 0);
            send_vector(0, corner[i], 0, 0);
            send_vector(0, 0, corner[i], 0);
        end
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_vector(32'h1, 32'hFFFF_FFFF, 32'h1, 0);
        send_vector(0, 0, 0, 0);
        drain();

        // Long receiver hold-off while the sender keeps streaming.
        hold_sink = 1'b1;
        for (int i = 0; i < 120; i++)
            send_vector($urandom(), $urandom(), $urandom(), 0);
        wait (sink_hold_done);
        drain();

        for (int i = 0; i < 380; i++) begin
            int mode;
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 40) == 0)
                send_vector(0, 0, 0, 1);
            else
                send_vector(rand_comp(mode), rand_comp(mode), rand_comp(mode),
                            (i / 64) % 2 == 0);
        end
        drain();
        repeat (LATENCY + 10) @(posedge clk);

        $display("Checked %0d results from directed corners, a full-stall burst",
                 board.checked);
        $display("and random vectors of mixed magnitude with random gaps.");
        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ sim.f @@
hw/rtl/vn_pkg.sv
hw/rtl/vn_isqrt.sv
hw/rtl/vn_divide.sv
hw/rtl/vector3_normalize_core.sv
tb/tb_top.sv
